@@ src/rbb_pkg.sv @@
// Shared types and constants for the run-length bitmap blit decoder.
package rbb_pkg;

   localparam int CANVAS_MAX_WIDTH  = 256;
   localparam int CANVAS_MAX_HEIGHT = 64;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 9;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CANVAS_WIDTH  = 3'd0,
      CSR_CANVAS_HEIGHT = 3'd1,
      CSR_ORIGIN_X      = 3'd2,
      CSR_ORIGIN_Y      = 3'd3,
      CSR_IMAGE_WIDTH   = 3'd4,
      CSR_IMAGE_HEIGHT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [8:0] canvas_width;
      logic [6:0] canvas_height;
      logic [7:0] origin_x;
      logic [5:0] origin_y;
      logic [8:0] image_width;
      logic [6:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic [13:0] address_a;
      logic [7:0]  value_a;
      logic [13:0] address_b;
      logic [7:0]  value_b;
      logic [1:0]  write_count;
      logic        last_of_item;
      logic        image_complete;
      logic        image_rejected;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic take;
      logic run_step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_run;
      logic run_last;
   } dp_status_type;

endpackage

@@ src/rbb_if.sv @@
// Handshake interfaces for the coded byte channel and the pixel write channel.
interface rbb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] coded_byte;
   logic       first_byte;

   modport source (output valid, output coded_byte, output first_byte, input ready);
   modport sink (input valid, input coded_byte, input first_byte, output ready);
   modport monitor (input valid, input ready, input coded_byte, input first_byte);
endinterface

interface rbb_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] address_a;
   logic [7:0]  value_a;
   logic [13:0] address_b;
   logic [7:0]  value_b;
   logic [1:0]  write_count;
   logic        last_of_item;
   logic        image_complete;
   logic        image_rejected;

   modport source (output valid, output address_a, output value_a, output address_b,
                   output value_b, output write_count, output last_of_item,
                   output image_complete, output image_rejected, input ready);
   modport sink (input valid, input address_a, input value_a, input address_b,
                 input value_b, input write_count, input last_of_item,
                 input image_complete, input image_rejected, output ready);
   modport monitor (input valid, input ready, input address_a, input value_a,
                    input address_b, input value_b, input write_count,
                    input last_of_item, input image_complete, input image_rejected);
endinterface

@@ src/rle_bitmap_blit_decoder.sv @@
// Top level of the run-length bitmap blit decoder.
//
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    coded_byte, first_byte
//   rsp_bus   out        valid/ready    two pixel writes, count and image flags
//   csr_*     in         write enable   register index and data
//
// A header, literal or skip byte gives one transaction.
// A repeat value is accepted without a result, then the burst sequencer issues one
// result per cycle while rsp_bus is not stalled, each holding up to two pixels.
// Reset is synchronous and restores register defaults and clears run state.
// The result register is reloaded only when it is empty or being taken, so a
// stalled output holds the current transaction and backs up into req_bus.
module rle_bitmap_blit_decoder
   import rbb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   rbb_req_if.sink                    req_bus,
   rbb_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   dp_status_type   status;
   rsp_payload_type rsp_payload;

   rbb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   rbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   rbb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .coded_byte  (req_bus.coded_byte),
      .first_byte  (req_bus.first_byte),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign rsp_bus.address_a      = rsp_payload.address_a;
   assign rsp_bus.value_a        = rsp_payload.value_a;
   assign rsp_bus.address_b      = rsp_payload.address_b;
   assign rsp_bus.value_b        = rsp_payload.value_b;
   assign rsp_bus.write_count    = rsp_payload.write_count;
   assign rsp_bus.last_of_item   = rsp_payload.last_of_item;
   assign rsp_bus.image_complete = rsp_payload.image_complete;
   assign rsp_bus.image_rejected = rsp_payload.image_rejected;

endmodule

@@ src/rbb_csr.sv @@
// Configuration registers for canvas and image geometry.
module rbb_csr
   import rbb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  cfg_in.canvas_width  = csr_data[8:0];
            CSR_CANVAS_HEIGHT: cfg_in.canvas_height = csr_data[6:0];
            CSR_ORIGIN_X:      cfg_in.origin_x      = csr_data[7:0];
            CSR_ORIGIN_Y:      cfg_in.origin_y      = csr_data[5:0];
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_data[8:0];
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_data[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width  <= 9'd256;
         cfg_ff.canvas_height <= 7'd64;
         cfg_ff.origin_x      <= 8'd0;
         cfg_ff.origin_y      <= 6'd0;
         cfg_ff.image_width   <= 9'd256;
         cfg_ff.image_height  <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/rbb_ctrl.sv @@
// Controller state machine that sequences byte acceptance and repeat bursts.
module rbb_ctrl
   import rbb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take && status.start_run) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.run_step && status.run_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.take     = 1'b0;
      cmd.run_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = slot_free;
            cmd.take  = req_valid && slot_free;
         end
         ST_RUN: begin
            cmd.run_step = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load_rsp = (cmd.take && !status.start_run) || cmd.run_step;
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/rbb_datapath.sv @@
// Decoder datapath: run state, pixel position, address arithmetic and result register.
module rbb_datapath
   import rbb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  ctrl_cmd_type    cmd,
   input  logic [7:0]      coded_byte,
   input  logic            first_byte,
   output dp_status_type   status,
   output rsp_payload_type rsp_payload
);

   typedef struct packed {
      logic [8:0] col;
      logic [6:0] row;
      logic       wrap;
      logic       fin;
   } adv_type;

   function automatic adv_type advance_pos(input logic [8:0] col, input logic [6:0] row,
                                           input logic [8:0] iw, input logic [6:0] ih);
      adv_type r;
      r.col  = col + 9'd1;
      r.row  = row;
      r.wrap = 1'b0;
      r.fin  = 1'b0;
      if (r.col >= iw) begin
         r.col  = 9'd0;
         r.row  = row + 7'd1;
         r.wrap = 1'b1;
         r.fin  = (r.row >= ih) || (r.row == 7'd0);
      end
      return r;
   endfunction

   logic [8:0] col_ff, col_in;
   logic [6:0] row_ff, row_in;
   logic [6:0] rep_ff, rep_in;
   logic [7:0] lit_ff, lit_in;
   logic       aw_ff, aw_in;
   logic       fin_ff, fin_in;
   logic [6:0] run_cnt_ff, run_cnt_in;
   logic [7:0] run_val_ff, run_val_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic        clear;
   logic [8:0]  e_col;
   logic [6:0]  e_row;
   logic [6:0]  e_rep;
   logic [7:0]  e_lit;
   logic        e_aw;
   logic        e_fin;
   logic        fits;
   logic        pos_bad;
   logic [7:0]  base_row;
   logic [16:0] row_offset;
   logic [13:0] addr_a;
   logic [13:0] addr_b;
   adv_type     adv1;
   adv_type     adv2;

   assign clear = cmd.take && first_byte;
   assign e_col = clear ? 9'd0 : col_ff;
   assign e_row = clear ? 7'd0 : row_ff;
   assign e_rep = clear ? 7'd0 : rep_ff;
   assign e_lit = clear ? 8'd0 : lit_ff;
   assign e_aw  = clear ? 1'b0 : aw_ff;
   assign e_fin = clear ? 1'b0 : fin_ff;

   always_comb begin
      fits = 1'b1;
      if (cfg.canvas_width == 9'd0 || 32'(cfg.canvas_width) > CANVAS_MAX_WIDTH) fits = 1'b0;
      if (cfg.canvas_height == 7'd0 || 32'(cfg.canvas_height) > CANVAS_MAX_HEIGHT) fits = 1'b0;
      if (({1'b0, cfg.image_width} + {2'b0, cfg.origin_x}) > {1'b0, cfg.canvas_width})
         fits = 1'b0;
      if (({1'b0, cfg.image_height} + {2'b0, cfg.origin_y}) > {1'b0, cfg.canvas_height})
         fits = 1'b0;
   end

   assign pos_bad = (cfg.image_width == 9'd0) || (cfg.image_height == 7'd0) ||
                    (e_row >= cfg.image_height) || (e_col >= cfg.image_width);

   assign base_row   = {2'b0, cfg.origin_y} + {1'b0, e_row};
   assign row_offset = base_row * cfg.canvas_width;
   assign addr_a     = row_offset[13:0] + 14'(cfg.origin_x) + 14'(e_col);

   assign adv1 = advance_pos(e_col, e_row, cfg.image_width, cfg.image_height);
   assign adv2 = advance_pos(adv1.col, adv1.row, cfg.image_width, cfg.image_height);

   assign addr_b = adv1.wrap ? (addr_a + 14'(cfg.canvas_width) - 14'(e_col))
                             : (addr_a + 14'd1);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      rep_in     = rep_ff;
      lit_in     = lit_ff;
      aw_in      = aw_ff;
      fin_in     = fin_ff;
      run_cnt_in = run_cnt_ff;
      run_val_in = run_val_ff;
      rsp_in     = '0;
      rsp_in.last_of_item = 1'b1;
      status.start_run = 1'b0;
      status.run_last  = 1'b0;

      if (cmd.take) begin
         col_in = e_col;
         row_in = e_row;
         rep_in = e_rep;
         lit_in = e_lit;
         aw_in  = e_aw;
         fin_in = e_fin;
         if (fits && !e_fin) begin
            if (pos_bad) begin
               fin_in = 1'b1;
               rep_in = 7'd0;
               lit_in = 8'd0;
               aw_in  = 1'b0;
            end else if (e_aw) begin
               aw_in  = 1'b0;
               rep_in = 7'd0;
               if (e_rep != 7'd0) begin
                  status.start_run = 1'b1;
                  run_cnt_in = e_rep;
                  run_val_in = coded_byte;
               end
            end else if (e_lit != 8'd0) begin
               lit_in = e_lit - 8'd1;
               rsp_in.write_count = 2'd1;
               rsp_in.address_a   = addr_a;
               rsp_in.value_a     = coded_byte;
               col_in = adv1.col;
               row_in = adv1.row;
               if (adv1.fin) begin
                  fin_in = 1'b1;
                  rep_in = 7'd0;
                  lit_in = 8'd0;
                  aw_in  = 1'b0;
               end
            end else if (coded_byte == 8'h00 || coded_byte == 8'h80) begin
               col_in = adv1.col;
               row_in = adv1.row;
               if (adv1.fin) begin
                  fin_in = 1'b1;
                  rep_in = 7'd0;
                  lit_in = 8'd0;
                  aw_in  = 1'b0;
               end
            end else if (!coded_byte[7]) begin
               rep_in = coded_byte[6:0];
               aw_in  = 1'b1;
            end else begin
               lit_in = 8'd0 - coded_byte;
            end
         end
         rsp_in.image_complete = fin_in;
         rsp_in.image_rejected = !fits;
      end else if (cmd.run_step) begin
         rsp_in.address_a = addr_a;
         rsp_in.value_a   = run_val_ff;
         if (adv1.fin) begin
            rsp_in.write_count = 2'd1;
            col_in     = adv1.col;
            row_in     = adv1.row;
            fin_in     = 1'b1;
            run_cnt_in = 7'd0;
            rsp_in.last_of_item = 1'b1;
         end else if (run_cnt_ff >= 7'd2) begin
            rsp_in.write_count = 2'd2;
            rsp_in.address_b   = addr_b;
            rsp_in.value_b     = run_val_ff;
            col_in     = adv2.col;
            row_in     = adv2.row;
            fin_in     = adv2.fin;
            run_cnt_in = adv2.fin ? 7'd0 : run_cnt_ff - 7'd2;
            rsp_in.last_of_item = adv2.fin || (run_cnt_ff == 7'd2);
         end else begin
            rsp_in.write_count = 2'd1;
            col_in     = adv1.col;
            row_in     = adv1.row;
            run_cnt_in = 7'd0;
            rsp_in.last_of_item = 1'b1;
         end
         if (fin_in) begin
            rep_in = 7'd0;
            lit_in = 8'd0;
            aw_in  = 1'b0;
         end
         rsp_in.image_complete = rsp_in.last_of_item && fin_in;
         rsp_in.image_rejected = 1'b0;
         status.run_last = rsp_in.last_of_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= 9'd0;
         row_ff     <= 7'd0;
         rep_ff     <= 7'd0;
         lit_ff     <= 8'd0;
         aw_ff      <= 1'b0;
         fin_ff     <= 1'b0;
         run_cnt_ff <= 7'd0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         rep_ff     <= rep_in;
         lit_ff     <= lit_in;
         aw_ff      <= aw_in;
         fin_ff     <= fin_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      run_val_ff <= run_val_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ src/rbb_checker.sv @@
// Port-level assertions for the decoder and the bind that attaches them.
module rbb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [13:0] rsp_address_a,
   input logic [13:0] rsp_address_b,
   input logic [7:0]  rsp_value_b,
   input logic [1:0]  rsp_write_count,
   input logic        rsp_last_of_item,
   input logic        rsp_image_complete,
   input logic        rsp_image_rejected
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_address_a) && $stable(rsp_write_count) &&
            $stable(rsp_last_of_item);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   property p_count_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_write_count != 2'd3;
   endproperty
   a_count_range: assert property (p_count_range) else $error("write count out of range");

   property p_reject_empty;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_image_rejected |->
            rsp_write_count == 2'd0 && rsp_last_of_item;
   endproperty
   a_reject_empty: assert property (p_reject_empty)
      else $error("rejected image produced a write");

   property p_complete_last;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_image_complete |-> rsp_last_of_item;
   endproperty
   a_complete_last: assert property (p_complete_last)
      else $error("image complete flagged before the last result");

   property p_slot_b_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_write_count != 2'd2 |->
            rsp_address_b == 14'd0 && rsp_value_b == 8'd0;
   endproperty
   a_slot_b_zero: assert property (p_slot_b_zero) else $error("unused second slot not zero");

endmodule

bind rle_bitmap_blit_decoder rbb_checker u_rbb_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_address_a      (rsp_bus.address_a),
   .rsp_address_b      (rsp_bus.address_b),
   .rsp_value_b        (rsp_bus.value_b),
   .rsp_write_count    (rsp_bus.write_count),
   .rsp_last_of_item   (rsp_bus.last_of_item),
   .rsp_image_complete (rsp_bus.image_complete),
   .rsp_image_rejected (rsp_bus.image_rejected)
);
